### sv/iol_pkg.sv
`timescale 1ns / 1ps
package iol_pkg;

    localparam int IOL_CAPACITY   = 16;
    localparam int IOL_DATA_WIDTH = 64;

    localparam logic [1:0] OP_FRONT  = 2'd0;
    localparam logic [1:0] OP_BACK   = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_DELETE = 2'd3;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  position;
        logic [63:0] entry_data;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] read_word;
        logic [4:0]  entry_count;
    } result_t;

    typedef struct packed {
        logic       ld;
        logic       rd;
        logic       wr_shift;
        logic       wr_word;
        logic       step;
        logic       fin;
        logic       fin_inc;
        logic       fin_dec;
        logic       fin_read;
        logic [1:0] fin_status;
    } cmd_t;

    typedef struct packed {
        logic is_insert;
        logic is_front;
        logic is_read;
        logic full;
        logic absent;
        logic more;
    } stat_t;

endpackage

### sv/iol_dpath.sv
`timescale 1ns / 1ps
module iol_dpath #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  iol_pkg::item_t  item,
    input  iol_pkg::cmd_t   cmd,
    output iol_pkg::stat_t  stat,
    output logic            done,
    output iol_pkg::result_t result
);
    import iol_pkg::*;

    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > 4) ? CW + 1 : 5;

    logic [DATA_WIDTH-1:0] mem [CAPACITY];

    logic [1:0]            op_reg;
    logic [3:0]            pos_reg;
    logic [DATA_WIDTH-1:0] word_reg;
    logic [CW-1:0]         cnt_reg;
    logic [CW-1:0]         cnt_next;
    logic [CW-1:0]         cur_reg;
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic                  done_reg;
    result_t               result_reg;

    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic                  wr_en;
    logic [CMPW-1:0]       cur_plus;

    assign cur_plus = CMPW'(cur_reg) + CMPW'(1);

    always_comb
    begin
        stat.is_insert = (op_reg == OP_FRONT) || (op_reg == OP_BACK);
        stat.is_front  = (op_reg == OP_FRONT);
        stat.is_read   = (op_reg == OP_READ);
        stat.full      = (CMPW'(cnt_reg) >= CMPW'(CAPACITY));
        stat.absent    = (CMPW'(pos_reg) >= CMPW'(cnt_reg));
        if (op_reg == OP_FRONT)
        begin
            stat.more = (cur_reg != '0);
        end
        else
        begin
            stat.more = (cur_plus < CMPW'(cnt_reg));
        end
    end

    always_comb
    begin
        case (op_reg)
            OP_FRONT:  rd_addr = AW'(cur_reg - CW'(1));
            OP_DELETE: rd_addr = cur_plus[AW-1:0];
            default:   rd_addr = AW'(pos_reg);
        endcase
    end

    always_comb
    begin
        wr_en   = cmd.wr_shift || cmd.wr_word;
        wr_data = rd_data_reg;
        wr_addr = cur_reg[AW-1:0];
        if (cmd.wr_word)
        begin
            wr_data = word_reg;
            wr_addr = (op_reg == OP_FRONT) ? '0 : cnt_reg[AW-1:0];
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.fin_inc)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (cmd.fin_dec)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld)
        begin
            op_reg   <= item.operation;
            pos_reg  <= item.position;
            word_reg <= item.entry_data[DATA_WIDTH-1:0];
            if (item.operation == OP_FRONT)
            begin
                cur_reg <= cnt_reg;
            end
            else
            begin
                cur_reg <= CW'(item.position);
            end
        end
        else if (cmd.step)
        begin
            if (op_reg == OP_FRONT)
            begin
                cur_reg <= cur_reg - CW'(1);
            end
            else
            begin
                cur_reg <= cur_reg + CW'(1);
            end
        end
        if (cmd.fin)
        begin
            result_reg.status      <= cmd.fin_status;
            result_reg.read_word   <= cmd.fin_read ? 64'(rd_data_reg) : 64'd0;
            result_reg.entry_count <= 5'(cnt_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.fin;
            if (cmd.fin)
            begin
                cnt_reg <= cnt_next;
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

### sv/iol_ctrl.sv
`timescale 1ns / 1ps
module iol_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  iol_pkg::stat_t stat,
    output iol_pkg::cmd_t  cmd,
    output logic           busy
);
    import iol_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EVAL  = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_WR    = 3'd3;
    localparam logic [2:0] S_PUT   = 3'd4;
    localparam logic [2:0] S_RWAIT = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.ld     = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (stat.is_insert)
                begin
                    if (stat.full)
                    begin
                        cmd.fin        = 1'b1;
                        cmd.fin_status = ST_FULL;
                        state_next     = S_IDLE;
                    end
                    else if (stat.is_front)
                    begin
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        state_next = S_PUT;
                    end
                end
                else if (stat.absent)
                begin
                    cmd.fin        = 1'b1;
                    cmd.fin_status = ST_ABSENT;
                    state_next     = S_IDLE;
                end
                else if (stat.is_read)
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_RWAIT;
                end
                else
                begin
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                if (stat.more)
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_WR;
                end
                else if (stat.is_front)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    cmd.fin        = 1'b1;
                    cmd.fin_dec    = 1'b1;
                    cmd.fin_status = ST_DONE;
                    state_next     = S_IDLE;
                end
            end
            S_WR:
            begin
                cmd.wr_shift = 1'b1;
                cmd.step     = 1'b1;
                state_next   = S_SHIFT;
            end
            S_PUT:
            begin
                cmd.wr_word    = 1'b1;
                cmd.fin        = 1'b1;
                cmd.fin_inc    = 1'b1;
                cmd.fin_status = ST_DONE;
                state_next     = S_IDLE;
            end
            S_RWAIT:
            begin
                cmd.fin        = 1'b1;
                cmd.fin_read   = 1'b1;
                cmd.fin_status = ST_DONE;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

### sv/indexed_ordered_list.sv
`timescale 1ns / 1ps
// Ordered list of up to CAPACITY entry words held in a single-port memory.
// Pulse start while busy is low to hand in one item; busy then stays high
// for the length of the operation and the result appears on result with done
// high for one cycle, in the cycle busy drops, with no way to hold it off.
// A new item can be accepted in that same cycle. Busy spans an evaluation
// state that alone ends a full insert or absent position; append adds a
// write, read a read wait, insert at front a read and write per entry moved
// plus a last check and the new word's write, delete a read and write per
// entry after position plus a last check. Entries move one word at a time.
module indexed_ordered_list #(
    parameter int CAPACITY   = iol_pkg::IOL_CAPACITY,
    parameter int DATA_WIDTH = iol_pkg::IOL_DATA_WIDTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  iol_pkg::item_t   item,
    output logic             done,
    output iol_pkg::result_t result
);
    import iol_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    iol_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    iol_dpath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .done   (done),
        .result (result)
    );

    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy)))
        else $error("result strobe without end of operation");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_FULL) |-> (result.entry_count == 5'(CAPACITY)))
        else $error("full status with list not at capacity");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != ST_DONE) |-> (result.read_word == 64'd0))
        else $error("failed item returned a nonzero word");

endmodule
